>>> rtl/core/cbe_pkg.sv
// shared constants, types and the control-value table for the bezier easing evaluator
// no dependencies; imported by every module under rtl/core
package cbe_pkg;

    localparam int BisectStepsDefault = 10;
    localparam int FracBitsDefault    = 16;

    localparam int CtrlW     = 7;
    localparam int IoW       = 17;
    localparam int IoFrac    = 16;
    localparam int CurveLat  = 3;
    localparam int CtrlCodes = 1 << CtrlW;

    localparam logic [IoW-1:0] IoOne = 17'd65536;
    localparam longint CtrlScale     = 127;

    // what travels beside the numbers: identity flag and saturated progress
    typedef struct packed {
        logic           ident;
        logic [IoW-1:0] prog;
    } cbe_tag_t;

    typedef logic [31:0] ctrl_tbl_t [CtrlCodes];

    // floor(c * 2^frac / 127) for every control code
    function automatic ctrl_tbl_t ctrl_table(input int frac_bits);
        ctrl_tbl_t tbl;
        for (int i = 0; i < CtrlCodes; i++) begin
            tbl[i] = 32'((longint'(i) << frac_bits) / CtrlScale);
        end
        return tbl;
    endfunction

endpackage

>>> rtl/core/cubic_bezier_easing_eval.sv
// top level of the cubic bezier easing evaluator: input stage, bisection cells, y curve, output
// depends on cbe_pkg, cbe_curve and cbe_cell
//
// Evaluates a cubic bezier easing curve for one progress value per request. The block takes
// a new request every clock cycle while s_ready is high; each request passes the input
// conversion register, one cell per bisection step (three pipelined multiply stages plus the
// compare-and-halve register), the pipelined final y curve and the output register. A two-entry
// output register and skid stage keep requests flowing while a result waits; s_ready only
// drops once both hold results. Identity curves (x1 == y1 and x2 == y2) travel through the
// same pipeline and return the saturated progress unchanged.
module cubic_bezier_easing_eval #(
    parameter int BISECT_STEPS = cbe_pkg::BisectStepsDefault,
    parameter int FRAC_BITS    = cbe_pkg::FracBitsDefault
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [cbe_pkg::CtrlW-1:0] s_ctrl_x1,
    input  logic [cbe_pkg::CtrlW-1:0] s_ctrl_y1,
    input  logic [cbe_pkg::CtrlW-1:0] s_ctrl_x2,
    input  logic [cbe_pkg::CtrlW-1:0] s_ctrl_y2,
    input  logic [cbe_pkg::IoW-1:0]   s_progress,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [cbe_pkg::IoW-1:0]   m_eased
);
    import cbe_pkg::*;

    localparam int FW = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 4;
    localparam int NC = BISECT_STEPS;
    localparam int LastD = CurveLat - 1;
    localparam logic [FW-1:0] FxOne = {1'b1, {FRAC_BITS{1'b0}}};
    localparam ctrl_tbl_t CtrlTbl = ctrl_table(FRAC_BITS);

    logic          ce;
    logic [IoW-1:0] prog_sat;
    logic [FW-1:0] t_w;

    logic          c_vld [NC+1];
    cbe_tag_t      c_tag [NC+1];
    logic [FW-1:0] c_t  [NC+1];
    logic [FW-1:0] c_lo [NC+1];
    logic [FW-1:0] c_hi [NC+1];
    logic [FW-1:0] c_s  [NC+1];
    logic [FW-1:0] c_x1 [NC+1];
    logic [FW-1:0] c_x2 [NC+1];
    logic [FW-1:0] c_y1 [NC+1];
    logic [FW-1:0] c_y2 [NC+1];

    logic          in_vld_reg;
    cbe_tag_t      in_tag_reg;
    logic [FW-1:0] in_t_reg, in_x1_reg, in_x2_reg, in_y1_reg, in_y2_reg;

    logic [SW-1:0] ysum_w;
    logic          yv_d_reg  [CurveLat];
    cbe_tag_t      ytag_d_reg [CurveLat];
    logic [31:0]   y_io;
    logic [IoW-1:0] res_w;

    logic           m_valid_reg, m_valid_next;
    logic [IoW-1:0] m_eased_reg, m_eased_next;
    logic           skid_valid_reg, skid_valid_next;
    logic [IoW-1:0] skid_eased_reg, skid_eased_next;

    // the whole pipeline advances unless the skid stage is occupied
    assign ce      = !skid_valid_reg;
    assign s_ready = ce;

    assign prog_sat = (s_progress > IoOne) ? IoOne : s_progress;

    generate
        if (FRAC_BITS >= IoFrac) begin : g_t_up
            assign t_w = FW'(prog_sat) << (FRAC_BITS - IoFrac);
        end else begin : g_t_dn
            assign t_w = FW'(prog_sat >> (IoFrac - FRAC_BITS));
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (ce) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            in_tag_reg.ident <= (s_ctrl_x1 == s_ctrl_y1) && (s_ctrl_x2 == s_ctrl_y2);
            in_tag_reg.prog  <= prog_sat;
            in_t_reg         <= t_w;
            in_x1_reg        <= CtrlTbl[s_ctrl_x1][FW-1:0];
            in_x2_reg        <= CtrlTbl[s_ctrl_x2][FW-1:0];
            in_y1_reg        <= CtrlTbl[s_ctrl_y1][FW-1:0];
            in_y2_reg        <= CtrlTbl[s_ctrl_y2][FW-1:0];
        end
    end

    // first probe is s = t over the full interval
    assign c_vld[0] = in_vld_reg;
    assign c_tag[0] = in_tag_reg;
    assign c_t[0]   = in_t_reg;
    assign c_lo[0]  = '0;
    assign c_hi[0]  = FxOne;
    assign c_s[0]   = in_t_reg;
    assign c_x1[0]  = in_x1_reg;
    assign c_x2[0]  = in_x2_reg;
    assign c_y1[0]  = in_y1_reg;
    assign c_y2[0]  = in_y2_reg;

    generate
        for (genvar k = 0; k < NC; k++) begin : g_cell
            cbe_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ce      (ce),
                .vld_in  (c_vld[k]),
                .tag_in  (c_tag[k]),
                .t_in    (c_t[k]),
                .lo_in   (c_lo[k]),
                .hi_in   (c_hi[k]),
                .s_in    (c_s[k]),
                .x1_in   (c_x1[k]),
                .x2_in   (c_x2[k]),
                .y1_in   (c_y1[k]),
                .y2_in   (c_y2[k]),
                .vld_out (c_vld[k+1]),
                .tag_out (c_tag[k+1]),
                .t_out   (c_t[k+1]),
                .lo_out  (c_lo[k+1]),
                .hi_out  (c_hi[k+1]),
                .s_out   (c_s[k+1]),
                .x1_out  (c_x1[k+1]),
                .x2_out  (c_x2[k+1]),
                .y1_out  (c_y1[k+1]),
                .y2_out  (c_y2[k+1])
            );
        end
    endgenerate

    cbe_curve #(.FRAC_BITS(FRAC_BITS)) u_ycurve (
        .aclk (aclk),
        .ce   (ce),
        .s    (c_s[NC]),
        .p1   (c_y1[NC]),
        .p2   (c_y2[NC]),
        .sum  (ysum_w)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CurveLat; i++) begin
                yv_d_reg[i] <= 1'b0;
            end
        end else if (ce) begin
            yv_d_reg[0] <= c_vld[NC];
            for (int i = 1; i < CurveLat; i++) begin
                yv_d_reg[i] <= yv_d_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ytag_d_reg[0] <= c_tag[NC];
            for (int i = 1; i < CurveLat; i++) begin
                ytag_d_reg[i] <= ytag_d_reg[i-1];
            end
        end
    end

    generate
        if (FRAC_BITS >= IoFrac) begin : g_y_dn
            assign y_io = 32'(ysum_w >> (FRAC_BITS - IoFrac));
        end else begin : g_y_up
            assign y_io = 32'(ysum_w) << (IoFrac - FRAC_BITS);
        end
    endgenerate

    always_comb begin
        if (ytag_d_reg[LastD].ident) begin
            res_w = ytag_d_reg[LastD].prog;
        end else if (y_io > 32'(IoOne)) begin
            res_w = IoOne;
        end else begin
            res_w = y_io[IoW-1:0];
        end
    end

    // output register with one skid entry behind it
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_eased_next    = m_eased_reg;
        skid_valid_next = skid_valid_reg;
        skid_eased_next = skid_eased_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next    = skid_valid_reg;
            m_eased_next    = skid_eased_reg;
            skid_valid_next = 1'b0;
        end
        if (ce && yv_d_reg[LastD]) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_next = 1'b1;
                m_eased_next = res_w;
            end else begin
                skid_valid_next = 1'b1;
                skid_eased_next = res_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_eased_reg    <= m_eased_next;
        skid_eased_reg <= skid_eased_next;
    end

    assign m_valid = m_valid_reg;
    assign m_eased = m_eased_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held without an output result");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid filled while output register was free");

    a_eased_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_eased_reg <= IoOne))
        else $error("eased result above one");

endmodule

>>> rtl/core/cbe_curve.sv
// three-stage pipelined evaluation of the cubic bezier basis with end points 0 and 1
// depends on cbe_pkg
module cbe_curve #(
    parameter int FRAC_BITS = cbe_pkg::FracBitsDefault
) (
    input  logic                 aclk,
    input  logic                 ce,
    input  logic [FRAC_BITS:0]   s,
    input  logic [FRAC_BITS:0]   p1,
    input  logic [FRAC_BITS:0]   p2,
    output logic [FRAC_BITS+3:0] sum
);
    import cbe_pkg::*;

    localparam int FW = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 4;
    localparam logic [FW-1:0] FxOne = {1'b1, {FRAC_BITS{1'b0}}};

    function automatic logic [FW-1:0] fx_mul(input logic [FW-1:0] a, input logic [FW-1:0] b);
        logic [2*FW-1:0] p;
        p = a * b;
        return p[FRAC_BITS+FW-1:FRAC_BITS];
    endfunction

    logic [FW-1:0] u;
    logic [FW-1:0] s_1_reg, u_1_reg, s2_1_reg, u2_1_reg, p1_1_reg, p2_1_reg;
    logic [FW-1:0] s3_2_reg, us2_2_reg, u2s_2_reg, p1_2_reg, p2_2_reg;
    logic [FW-1:0] a_3_reg, b_3_reg, s3_3_reg;

    assign u = FxOne - s;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s_1_reg   <= s;
            u_1_reg   <= u;
            s2_1_reg  <= fx_mul(s, s);
            u2_1_reg  <= fx_mul(u, u);
            p1_1_reg  <= p1;
            p2_1_reg  <= p2;

            s3_2_reg  <= fx_mul(s2_1_reg, s_1_reg);
            us2_2_reg <= fx_mul(u_1_reg, s2_1_reg);
            u2s_2_reg <= fx_mul(u2_1_reg, s_1_reg);
            p1_2_reg  <= p1_1_reg;
            p2_2_reg  <= p2_1_reg;

            a_3_reg   <= fx_mul(u2s_2_reg, p1_2_reg);
            b_3_reg   <= fx_mul(us2_2_reg, p2_2_reg);
            s3_3_reg  <= s3_2_reg;
        end
    end

    // 3a + 3b + s^3
    assign sum = SW'(a_3_reg) + (SW'(a_3_reg) << 1)
               + SW'(b_3_reg) + (SW'(b_3_reg) << 1) + SW'(s3_3_reg);

endmodule

>>> rtl/core/cbe_cell.sv
// one bisection step: probe x(s), narrow the bounds, hand the midpoint on
// depends on cbe_pkg and cbe_curve
module cbe_cell #(
    parameter int FRAC_BITS = cbe_pkg::FracBitsDefault
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ce,
    input  logic                  vld_in,
    input  cbe_pkg::cbe_tag_t     tag_in,
    input  logic [FRAC_BITS:0]    t_in,
    input  logic [FRAC_BITS:0]    lo_in,
    input  logic [FRAC_BITS:0]    hi_in,
    input  logic [FRAC_BITS:0]    s_in,
    input  logic [FRAC_BITS:0]    x1_in,
    input  logic [FRAC_BITS:0]    x2_in,
    input  logic [FRAC_BITS:0]    y1_in,
    input  logic [FRAC_BITS:0]    y2_in,
    output logic                  vld_out,
    output cbe_pkg::cbe_tag_t     tag_out,
    output logic [FRAC_BITS:0]    t_out,
    output logic [FRAC_BITS:0]    lo_out,
    output logic [FRAC_BITS:0]    hi_out,
    output logic [FRAC_BITS:0]    s_out,
    output logic [FRAC_BITS:0]    x1_out,
    output logic [FRAC_BITS:0]    x2_out,
    output logic [FRAC_BITS:0]    y1_out,
    output logic [FRAC_BITS:0]    y2_out
);
    import cbe_pkg::*;

    localparam int FW = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 4;
    localparam int LastD = CurveLat - 1;

    logic [SW-1:0] x_w;
    logic [FW-1:0] lo_next, hi_next;
    logic [FW:0]   mid_w;

    logic          vld_d_reg [CurveLat];
    cbe_tag_t      tag_d_reg [CurveLat];
    logic [FW-1:0] t_d_reg  [CurveLat];
    logic [FW-1:0] lo_d_reg [CurveLat];
    logic [FW-1:0] hi_d_reg [CurveLat];
    logic [FW-1:0] s_d_reg  [CurveLat];
    logic [FW-1:0] x1_d_reg [CurveLat];
    logic [FW-1:0] x2_d_reg [CurveLat];
    logic [FW-1:0] y1_d_reg [CurveLat];
    logic [FW-1:0] y2_d_reg [CurveLat];

    logic          vld_reg;
    cbe_tag_t      tag_reg;
    logic [FW-1:0] t_reg, lo_reg, hi_reg, s_reg, x1_reg, x2_reg, y1_reg, y2_reg;

    cbe_curve #(.FRAC_BITS(FRAC_BITS)) u_curve (
        .aclk (aclk),
        .ce   (ce),
        .s    (s_in),
        .p1   (x1_in),
        .p2   (x2_in),
        .sum  (x_w)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CurveLat; i++) begin
                vld_d_reg[i] <= 1'b0;
            end
            vld_reg <= 1'b0;
        end else if (ce) begin
            vld_d_reg[0] <= vld_in;
            for (int i = 1; i < CurveLat; i++) begin
                vld_d_reg[i] <= vld_d_reg[i-1];
            end
            vld_reg <= vld_d_reg[LastD];
        end
    end

    // side data waits alongside the curve pipeline
    always_ff @(posedge aclk) begin
        if (ce) begin
            tag_d_reg[0] <= tag_in;
            t_d_reg[0]   <= t_in;
            lo_d_reg[0]  <= lo_in;
            hi_d_reg[0]  <= hi_in;
            s_d_reg[0]   <= s_in;
            x1_d_reg[0]  <= x1_in;
            x2_d_reg[0]  <= x2_in;
            y1_d_reg[0]  <= y1_in;
            y2_d_reg[0]  <= y2_in;
            for (int i = 1; i < CurveLat; i++) begin
                tag_d_reg[i] <= tag_d_reg[i-1];
                t_d_reg[i]   <= t_d_reg[i-1];
                lo_d_reg[i]  <= lo_d_reg[i-1];
                hi_d_reg[i]  <= hi_d_reg[i-1];
                s_d_reg[i]   <= s_d_reg[i-1];
                x1_d_reg[i]  <= x1_d_reg[i-1];
                x2_d_reg[i]  <= x2_d_reg[i-1];
                y1_d_reg[i]  <= y1_d_reg[i-1];
                y2_d_reg[i]  <= y2_d_reg[i-1];
            end
        end
    end

    // equal probe moves the lower bound
    always_comb begin
        lo_next = lo_d_reg[LastD];
        hi_next = hi_d_reg[LastD];
        if (x_w > SW'(t_d_reg[LastD])) begin
            hi_next = s_d_reg[LastD];
        end else begin
            lo_next = s_d_reg[LastD];
        end
        mid_w = {1'b0, lo_next} + {1'b0, hi_next};
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tag_reg <= tag_d_reg[LastD];
            t_reg   <= t_d_reg[LastD];
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            s_reg   <= mid_w[FW:1];
            x1_reg  <= x1_d_reg[LastD];
            x2_reg  <= x2_d_reg[LastD];
            y1_reg  <= y1_d_reg[LastD];
            y2_reg  <= y2_d_reg[LastD];
        end
    end

    assign vld_out = vld_reg;
    assign tag_out = tag_reg;
    assign t_out   = t_reg;
    assign lo_out  = lo_reg;
    assign hi_out  = hi_reg;
    assign s_out   = s_reg;
    assign x1_out  = x1_reg;
    assign x2_out  = x2_reg;
    assign y1_out  = y1_reg;
    assign y2_out  = y2_reg;

endmodule

>>> tb/cubic_bezier_easing_eval_tb.sv
// self-checking testbench for the cubic bezier easing evaluator
// depends on cbe_pkg and cubic_bezier_easing_eval; predicts each eased value in fixed point
module cubic_bezier_easing_eval_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbe_pkg::*;

    localparam int StepCount = 10;
    localparam int Frac      = 16;
    localparam int Latency   = 4 * StepCount + 5;
    localparam int IdleLimit = 5000;
    localparam int HoldCycles = 1000;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [CtrlW-1:0] s_ctrl_x1;
    logic [CtrlW-1:0] s_ctrl_y1;
    logic [CtrlW-1:0] s_ctrl_x2;
    logic [CtrlW-1:0] s_ctrl_y2;
    logic [IoW-1:0]   s_progress;
    logic             m_valid;
    logic             m_ready;
    logic [IoW-1:0]   m_eased;

    logic [IoW-1:0] eased_expected[$];
    int             mismatches;
    int             idle_cycles;
    bit             timed_out;
    bit             sink_hold;
    bit             sink_random;

    cubic_bezier_easing_eval uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_ctrl_x1  (s_ctrl_x1),
        .s_ctrl_y1  (s_ctrl_y1),
        .s_ctrl_x2  (s_ctrl_x2),
        .s_ctrl_y2  (s_ctrl_y2),
        .s_progress (s_progress),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_eased    (m_eased)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        return (a * b) >> Frac;
    endfunction

    function automatic longint unsigned bezier_at(longint unsigned s, longint unsigned p1,
                                                  longint unsigned p2);
        longint unsigned u, s2;
        u  = (64'd1 << Frac) - s;
        s2 = qmul(s, s);
        return 3 * qmul(qmul(qmul(u, u), s), p1) + 3 * qmul(qmul(u, s2), p2) + qmul(s2, s);
    endfunction

    function automatic longint unsigned ctrl_to_fx(logic [CtrlW-1:0] c);
        return (longint'(c) << Frac) / 127;
    endfunction

    function automatic logic [IoW-1:0] predict_eased(logic [CtrlW-1:0] cx1, cy1, cx2, cy2,
                                                     logic [IoW-1:0] prog);
        longint unsigned t, lo, hi, s, x, y;
        longint unsigned fx1, fy1, fx2, fy2;
        t = (prog > IoOne) ? IoOne : prog;
        if (cx1 == cy1 && cx2 == cy2) return IoW'(t);
        fx1 = ctrl_to_fx(cx1);
        fy1 = ctrl_to_fx(cy1);
        fx2 = ctrl_to_fx(cx2);
        fy2 = ctrl_to_fx(cy2);
        lo = 0;
        hi = 64'd1 << Frac;
        s  = t;
        for (int i = 0; i < StepCount; i++) begin
            x = bezier_at(s, fx1, fx2);
            if (x > t) hi = s;
            else lo = s;
            s = (lo + hi) >> 1;
        end
        y = bezier_at(s, fy1, fy2);
        if (y > IoOne) y = IoOne;
        return IoW'(y);
    endfunction

    // one request: random gap, then hold valid until accepted
    // valid stays high on return so a request with no gap follows directly
    task automatic send_request(logic [CtrlW-1:0] cx1, cy1, cx2, cy2, logic [IoW-1:0] prog);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_ctrl_x1  <= cx1;
        s_ctrl_y1  <= cy1;
        s_ctrl_x2  <= cx2;
        s_ctrl_y2  <= cy2;
        s_progress <= prog;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        eased_expected.insert(eased_expected.size(), predict_eased(cx1, cy1, cx2, cy2, prog));
        @(negedge aclk);
    endtask

    task automatic run_directed;
        logic [IoW-1:0] edges[6];
        edges = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536, 17'h1FFFF};
        foreach (edges[i]) send_request(7'd42, 7'd0, 7'd74, 7'd127, edges[i]);
        send_request(7'd0, 7'd0, 7'd127, 7'd127, 17'd40000);
        send_request(7'd127, 7'd127, 7'd0, 7'd0, 17'd70000);
        send_request(7'd127, 7'd0, 7'd0, 7'd127, 17'd32768);
        send_request(7'd0, 7'd127, 7'd127, 7'd0, 17'd12345);
        send_request(7'd127, 7'd127, 7'd127, 7'd0, 17'd65536);
        send_request(7'd0, 7'd0, 7'd0, 7'd127, 17'd0);
        send_request(7'd127, 7'd0, 7'd127, 7'd0, 17'd65535);
        // midpoint symmetric curve, x(s) hits t exactly at the first probe
        send_request(7'd0, 7'd10, 7'd127, 7'd117, 17'd32768);
        send_request(7'd64, 7'd64, 7'd64, 7'd64, 17'h10001);
    endtask

    task automatic run_random(int count);
        logic [CtrlW-1:0] c[4];
        logic [IoW-1:0]   prog;
        for (int n = 0; n < count; n++) begin
            foreach (c[i]) c[i] = CtrlW'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                c[1] = c[0];
                c[3] = c[2];
            end
            case ($urandom_range(0, 7))
                0:       prog = IoW'($urandom);
                1:       prog = IoOne;
                default: prog = IoW'($urandom_range(0, 65536));
            endcase
            send_request(c[0], c[1], c[2], c[3], prog);
        end
    endtask

    // receiver stalls for a long stretch while requests keep coming
    task automatic run_backpressure;
        sink_hold = 1'b1;
        fork
            run_random(80);
            begin
                repeat (HoldCycles) @(posedge aclk);
                sink_hold = 1'b0;
            end
        join
    endtask

    task automatic run_streaming;
        sink_random = 1'b0;
        run_random(200);
        sink_random = 1'b1;
    endtask

    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold) begin
                m_ready <= 1'b0;
            end else if (!sink_random) begin
                m_ready <= 1'b1;
            end else begin
                gap = $urandom_range(0, 15);
                if ($urandom_range(0, 3) == 0) gap = 0;
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                    @(negedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk);
                while (!(m_valid && m_ready)) @(posedge aclk);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (eased_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result eased=%0d", m_eased);
            end else begin
                logic [IoW-1:0] want;
                want = eased_expected.pop_front();
                if (m_eased !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("eased mismatch: expected %0d got %0d", want, m_eased);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            timed_out = 1'b1;
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int waited;
        mismatches  = 0;
        idle_cycles = 0;
        timed_out   = 1'b0;
        sink_hold   = 1'b0;
        sink_random = 1'b1;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_ctrl_x1  = '0;
        s_ctrl_y1  = '0;
        s_ctrl_x2  = '0;
        s_ctrl_y2  = '0;
        s_progress = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        run_directed();
        run_backpressure();
        run_streaming();
        run_random(1400);
        s_valid <= 1'b0;

        waited = 0;
        while (eased_expected.size() != 0 && waited < 20 * IdleLimit) begin
            @(posedge aclk);
            waited++;
        end
        repeat (Latency) @(posedge aclk);
        if (mismatches == 0 && eased_expected.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
